[sv/wta_pkg.sv]
// Shared types and constants for the wrapping timer alarm table.
`timescale 1ns / 1ps

package wta_pkg;

  localparam int ALARM_COUNT_DEF = 16;
  localparam int TICK_BITS_DEF   = 16;

  localparam int CMD_W  = 2;
  localparam int ID_W   = 8;
  localparam int NOW_W  = 16;
  localparam int TOUT_W = 16;
  localparam int MOD_W  = 17;

  localparam logic [MOD_W-1:0] MOD_RESET = 17'h10000;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET   = 2'd0,
    CMD_CHECK = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic expired;
    logic active;
    logic status;
  } res_t;

endpackage

[sv/wrapping_timer_alarm_table.sv]
// Top level of the wrapping timer alarm table.
`timescale 1ns / 1ps

// Alarm table on one free-running timer. A command beat is taken whenever start is high
// (busy stays low) and gives exactly one result via the input and result registers:
// out_valid is high for one cycle with out_expired, out_active and out_status. The block
// takes a beat every cycle; the input register with the registered read of the entry
// memory forms the first stage and the flag update plus result register the second. The
// receiver cannot stall. The user must write the timer modulus through cfg_* only while
// no command is in flight; the block itself does not enforce it. cfg_ready is always high.
// No clearing pass after reset: the entry words are only used for alarms that were set.
module wrapping_timer_alarm_table #(
  parameter int ALARM_COUNT = wta_pkg::ALARM_COUNT_DEF,
  parameter int TICK_BITS   = wta_pkg::TICK_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [wta_pkg::CMD_W-1:0]   in_cmd,
  input  logic [wta_pkg::ID_W-1:0]    in_alarm_id,
  input  logic [wta_pkg::NOW_W-1:0]   in_now_tick,
  input  logic [wta_pkg::TOUT_W-1:0]  in_timeout,
  output logic                        out_valid,
  output logic                        out_expired,
  output logic                        out_active,
  output logic                        out_status,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [wta_pkg::MOD_W-1:0]   cfg_data
);

  localparam int IDX_W = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;
  localparam int DW    = 2 * TICK_BITS + 1;

  logic                         acc;
  logic                         id_ok;
  logic [IDX_W-1:0]             in_idx;
  logic                         v_r;
  logic [wta_pkg::CMD_W-1:0]    cmd_r;
  logic                         id_ok_r;
  logic [IDX_W-1:0]             idx_r;
  logic [wta_pkg::NOW_W-1:0]    now_r;
  logic [wta_pkg::TOUT_W-1:0]   tout_r;
  logic [wta_pkg::MOD_W-1:0]    mod_r;
  logic [DW-1:0]                ent_rd;
  logic                         wr_en;
  logic [IDX_W-1:0]             wr_addr;
  logic [DW-1:0]                wr_data;
  wta_pkg::res_t                res;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;
  assign id_ok     = {1'b0, in_alarm_id} < (wta_pkg::ID_W + 1)'(ALARM_COUNT);
  assign in_idx    = id_ok ? in_alarm_id[IDX_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      mod_r <= wta_pkg::MOD_RESET;
    end else begin
      v_r <= acc;
      if (cfg_valid && cfg_ready) begin
        mod_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cmd_r   <= in_cmd;
      id_ok_r <= id_ok;
      idx_r   <= in_idx;
      now_r   <= in_now_tick;
      tout_r  <= in_timeout;
    end
  end

  wta_entry_mem #(
    .DEPTH (ALARM_COUNT),
    .IDX_W (IDX_W),
    .DW    (DW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (in_idx),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (ent_rd)
  );

  wta_exec #(
    .ALARM_COUNT (ALARM_COUNT),
    .TICK_BITS   (TICK_BITS),
    .IDX_W       (IDX_W)
  ) u_exec (
    .clk     (clk),
    .rst_n   (rst_n),
    .v_r     (v_r),
    .cmd_r   (cmd_r),
    .id_ok_r (id_ok_r),
    .idx_r   (idx_r),
    .now_r   (now_r),
    .tout_r  (tout_r),
    .mod_r   (mod_r),
    .ent_rd  (ent_rd),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .res     (res)
  );

  assign out_valid   = res.valid;
  assign out_expired = res.expired;
  assign out_active  = res.active;
  assign out_status  = res.status;

endmodule

[sv/wta_entry_mem.sv]
// Alarm entry memory: start tick, deadline tick and before-wrap bit per alarm.
`timescale 1ns / 1ps

module wta_entry_mem #(
  parameter int DEPTH = wta_pkg::ALARM_COUNT_DEF,
  parameter int IDX_W = 4,
  parameter int DW    = 2 * wta_pkg::TICK_BITS_DEF + 1
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [DW-1:0]    wr_data,
  output logic [DW-1:0]    rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // write-first forward: a beat reading the entry being written sees the new word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/wta_exec.sv]
// Execute stage: deadline math, expiry check, alarm flags and result register.
`timescale 1ns / 1ps

module wta_exec #(
  parameter int ALARM_COUNT = wta_pkg::ALARM_COUNT_DEF,
  parameter int TICK_BITS   = wta_pkg::TICK_BITS_DEF,
  parameter int IDX_W       = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          v_r,
  input  logic [wta_pkg::CMD_W-1:0]     cmd_r,
  input  logic                          id_ok_r,
  input  logic [IDX_W-1:0]              idx_r,
  input  logic [wta_pkg::NOW_W-1:0]     now_r,
  input  logic [wta_pkg::TOUT_W-1:0]    tout_r,
  input  logic [wta_pkg::MOD_W-1:0]     mod_r,
  input  logic [2*TICK_BITS:0]          ent_rd,
  output logic                          wr_en,
  output logic [IDX_W-1:0]              wr_addr,
  output logic [2*TICK_BITS:0]          wr_data,
  output wta_pkg::res_t                 res
);

  // arithmetic width: holds the modulus and the raw now + timeout sum
  localparam int AW = (TICK_BITS + 1 > wta_pkg::MOD_W) ? TICK_BITS + 1 : wta_pkg::MOD_W;
  // compare width: raw tick against stored ticks
  localparam int CW = (TICK_BITS > wta_pkg::NOW_W) ? TICK_BITS : wta_pkg::NOW_W;

  logic [ALARM_COUNT-1:0] act_r, act_nxt;
  logic [ALARM_COUNT-1:0] exp_r, exp_nxt;
  wta_pkg::res_t          res_r, res_nxt;

  logic [AW-1:0]        top, mod_ext, mod_eff, sum_raw, sum_red;
  logic [TICK_BITS-1:0] new_start, new_dead;
  logic                 new_bw;
  logic [TICK_BITS-1:0] ent_start, ent_dead;
  logic                 ent_bw;
  logic [CW-1:0]        t, s, d;
  logic                 hit, tout_err, err, is_set, is_check;
  logic                 cur_act, cur_exp, act_new, exp_new;

  assign top     = AW'(1) << TICK_BITS;
  assign mod_ext = AW'(mod_r);

  always_comb begin
    if (mod_r == '0) begin
      mod_eff = AW'(1);
    end else if (mod_ext > top) begin
      mod_eff = top;
    end else begin
      mod_eff = mod_ext;
    end
  end

  assign sum_raw   = AW'(now_r) + AW'(tout_r);
  assign sum_red   = (sum_raw >= mod_eff) ? (sum_raw - mod_eff) : sum_raw;
  assign new_start = TICK_BITS'(now_r);
  assign new_dead  = sum_red[TICK_BITS-1:0];
  assign new_bw    = new_dead > new_start;
  assign tout_err  = AW'(tout_r) > mod_eff;

  assign ent_start = ent_rd[TICK_BITS-1:0];
  assign ent_dead  = ent_rd[2*TICK_BITS-1:TICK_BITS];
  assign ent_bw    = ent_rd[2*TICK_BITS];

  assign t = CW'(now_r);
  assign s = CW'(ent_start);
  assign d = CW'(ent_dead);

  // wrap-aware expiry; deadline equal to start never fires
  assign hit = ent_bw ? ((t >= d) || (t < s)) : ((t < s) && (t >= d));

  always_comb begin
    is_set   = 1'b0;
    is_check = 1'b0;
    case (wta_pkg::cmd_t'(cmd_r))
      wta_pkg::CMD_SET:   is_set   = 1'b1;
      wta_pkg::CMD_CHECK: is_check = 1'b1;
      wta_pkg::CMD_READ:  ;
      default:            ;
    endcase
  end

  assign err     = !id_ok_r || (is_set && tout_err);
  assign cur_act = act_r[idx_r];
  assign cur_exp = exp_r[idx_r];

  always_comb begin
    act_new = cur_act;
    exp_new = cur_exp;
    if (is_set) begin
      act_new = 1'b1;
      exp_new = 1'b0;
    end else if (is_check && cur_act && !cur_exp && hit) begin
      act_new = 1'b0;
      exp_new = 1'b1;
    end
  end

  assign wr_en   = v_r && !err && is_set;
  assign wr_addr = idx_r;
  assign wr_data = {new_bw, new_dead, new_start};

  always_comb begin
    act_nxt = act_r;
    exp_nxt = exp_r;
    if (v_r && !err) begin
      act_nxt[idx_r] = act_new;
      exp_nxt[idx_r] = exp_new;
    end
  end

  always_comb begin
    res_nxt.valid   = v_r;
    res_nxt.status  = err;
    res_nxt.active  = err ? 1'b0 : act_new;
    res_nxt.expired = err ? 1'b0 : exp_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0;
      exp_r <= '0;
      res_r <= '0;
    end else begin
      act_r <= act_nxt;
      exp_r <= exp_nxt;
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    res_r.valid |-> !(res_r.active && res_r.expired))
    else $error("result shows an alarm both active and expired");

  a_bad_id_err: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r && !id_ok_r) |=> (res_r.valid && res_r.status && !res_r.active && !res_r.expired))
    else $error("invalid id did not give an error result");

  a_set_arms: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (res_r.valid && res_r.active && !res_r.expired && !res_r.status))
    else $error("accepted set did not arm the alarm");

  a_result_one_per_item: assert property (@(posedge clk) disable iff (!rst_n)
    res_r.valid |-> $past(v_r))
    else $error("result strobe without a stage beat");

endmodule

[bench/wrapping_timer_alarm_table_tb.sv]
// Self-checking testbench for the wrapping timer alarm table.
`timescale 1ns / 1ps

module wrapping_timer_alarm_table_tb;

  localparam int ALARMS   = wta_pkg::ALARM_COUNT_DEF;
  localparam int WD_LIMIT = 2000;
  localparam int PHASES   = 10;
  localparam int PHASE_CMDS = 183;
  localparam logic [wta_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic [wta_pkg::CMD_W-1:0]  cmd;
    logic [wta_pkg::ID_W-1:0]   id;
    logic [wta_pkg::NOW_W-1:0]  now;
    logic [wta_pkg::TOUT_W-1:0] tout;
  } alarm_cmd_t;

  typedef struct packed {
    logic expired;
    logic active;
    logic status;
  } alarm_flags_t;

  typedef struct packed {
    alarm_cmd_t   beat;
    logic         known;
    alarm_flags_t flags;
  } dir_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [wta_pkg::CMD_W-1:0]  in_cmd = '0;
  logic [wta_pkg::ID_W-1:0]   in_alarm_id = '0;
  logic [wta_pkg::NOW_W-1:0]  in_now_tick = '0;
  logic [wta_pkg::TOUT_W-1:0] in_timeout = '0;
  logic                       out_valid;
  logic                       out_expired;
  logic                       out_active;
  logic                       out_status;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [wta_pkg::MOD_W-1:0]  cfg_data = '0;

  wrapping_timer_alarm_table u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_cmd      (in_cmd),
    .in_alarm_id (in_alarm_id),
    .in_now_tick (in_now_tick),
    .in_timeout  (in_timeout),
    .out_valid   (out_valid),
    .out_expired (out_expired),
    .out_active  (out_active),
    .out_status  (out_status),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow copy of the alarm table and the timer period.
  logic [wta_pkg::MOD_W-1:0]  tb_modulus = wta_pkg::MOD_RESET;
  logic [wta_pkg::NOW_W-1:0]  al_start    [ALARMS];
  logic [wta_pkg::NOW_W-1:0]  al_deadline [ALARMS];
  logic                       al_before_wrap [ALARMS];
  logic                       al_active   [ALARMS];
  logic                       al_expired  [ALARMS];

  alarm_flags_t flags_due [$];
  int           mismatch_count = 0;
  int           idle_cycles = 0;
  bit           quiet = 1'b0;

  dir_row_t directed_rows [24] = '{
    '{'{wta_pkg::CMD_READ,  8'd0,   16'd0,     16'd0},     1'b1, 3'b000},
    '{'{wta_pkg::CMD_CHECK, 8'd15,  16'hFFFF,  16'd0},     1'b1, 3'b000},
    '{'{wta_pkg::CMD_READ,  8'd255, 16'hFFFF,  16'hFFFF},  1'b1, 3'b001},
    '{'{wta_pkg::CMD_SET,   8'd16,  16'd5,     16'd5},     1'b1, 3'b001},
    '{'{wta_pkg::CMD_SET,   8'd0,   16'd100,   16'd0},     1'b1, 3'b010},
    '{'{wta_pkg::CMD_CHECK, 8'd0,   16'd50,    16'd0},     1'b0, 3'b000},
    '{'{wta_pkg::CMD_CHECK, 8'd0,   16'd100,   16'd0},     1'b0, 3'b000},
    '{'{wta_pkg::CMD_SET,   8'd1,   16'd1000,  16'd500},   1'b0, 3'b000},
    '{'{wta_pkg::CMD_CHECK, 8'd1,   16'd1499,  16'd0},     1'b0, 3'b000},
    '{'{wta_pkg::CMD_CHECK, 8'd1,   16'd1500,  16'd0},     1'b0, 3'b000},
    '{'{wta_pkg::CMD_CHECK, 8'd1,   16'd0,     16'd0},     1'b0, 3'b000},
    '{'{wta_pkg::CMD_SET,   8'd2,   16'd65000, 16'd1000},  1'b0, 3'b000},
    '{'{wta_pkg::CMD_CHECK, 8'd2,   16'd65535, 16'd0},     1'b0, 3'b000},
    '{'{wta_pkg::CMD_CHECK, 8'd2,   16'd100,   16'd0},     1'b0, 3'b000},
    '{'{wta_pkg::CMD_CHECK, 8'd2,   16'd464,   16'd0},     1'b0, 3'b000},
    '{'{wta_pkg::CMD_SET,   8'd3,   16'd65535, 16'd65535}, 1'b0, 3'b000},
    '{'{wta_pkg::CMD_CHECK, 8'd3,   16'd65533, 16'd0},     1'b0, 3'b000},
    '{'{wta_pkg::CMD_CHECK, 8'd3,   16'd65534, 16'd0},     1'b0, 3'b000},
    '{'{wta_pkg::CMD_SET,   8'd4,   16'd0,     16'd65535}, 1'b0, 3'b000},
    '{'{wta_pkg::CMD_CHECK, 8'd4,   16'd65535, 16'd0},     1'b0, 3'b000},
    '{'{CMD_SPARE,          8'd4,   16'd0,     16'd0},     1'b0, 3'b000},
    '{'{wta_pkg::CMD_SET,   8'd5,   16'hAAAA,  16'h5555},  1'b0, 3'b000},
    '{'{wta_pkg::CMD_CHECK, 8'd5,   16'h1234,  16'd0},     1'b0, 3'b000},
    '{'{wta_pkg::CMD_READ,  8'd5,   16'hFFFF,  16'hFFFF},  1'b0, 3'b000}
  };

  initial begin
    for (int i = 0; i < ALARMS; i++) begin
      al_start[i] = '0;
      al_deadline[i] = '0;
      al_before_wrap[i] = 1'b0;
      al_active[i] = 1'b0;
      al_expired[i] = 1'b0;
    end
  end

  // Zero acts as one, anything above 2^16 as 2^16.
  function automatic logic [17:0] eff_modulus();
    if (tb_modulus == '0) return 18'd1;
    if (tb_modulus > 17'h10000) return 18'h10000;
    return {1'b0, tb_modulus};
  endfunction

  function automatic alarm_flags_t apply_alarm_cmd(alarm_cmd_t c);
    logic [17:0]  m;
    logic [17:0]  sum;
    logic         hit;
    int           k;
    alarm_flags_t r;
    m = eff_modulus();
    if (c.id >= ALARMS) return '{expired: 1'b0, active: 1'b0, status: 1'b1};
    k = int'(c.id);
    if (c.cmd == wta_pkg::CMD_SET) begin
      if ({2'b0, c.tout} > m) return '{expired: 1'b0, active: 1'b0, status: 1'b1};
      sum = {2'b0, c.now} + {2'b0, c.tout};
      if (sum >= m) sum = sum - m;
      al_start[k] = c.now;
      al_deadline[k] = sum[wta_pkg::NOW_W-1:0];
      al_before_wrap[k] = sum[wta_pkg::NOW_W-1:0] > c.now;
      al_expired[k] = 1'b0;
      al_active[k] = 1'b1;
    end else if (c.cmd == wta_pkg::CMD_CHECK && al_active[k] && !al_expired[k]) begin
      if (al_before_wrap[k])
        hit = (c.now >= al_deadline[k]) || (c.now < al_start[k]);
      else
        hit = (c.now < al_start[k]) && (c.now >= al_deadline[k]);
      if (hit) begin
        al_active[k] = 1'b0;
        al_expired[k] = 1'b1;
      end
    end
    r.expired = al_expired[k];
    r.active = al_active[k];
    r.status = 1'b0;
    return r;
  endfunction

  function automatic alarm_cmd_t pick_cmd();
    alarm_cmd_t c;
    int         roll;
    int         em;
    int         k;
    em = int'(eff_modulus());
    roll = $urandom_range(99);
    if (roll < 30) c.cmd = wta_pkg::CMD_SET;
    else if (roll < 80) c.cmd = wta_pkg::CMD_CHECK;
    else if (roll < 94) c.cmd = wta_pkg::CMD_READ;
    else c.cmd = CMD_SPARE;
    c.id = ($urandom_range(99) < 90) ? 8'($urandom_range(ALARMS - 1))
                                     : 8'($urandom_range(255));
    c.now = ($urandom_range(99) < 85) ? 16'($urandom_range(em - 1)) : 16'($urandom);
    // steer checks onto the edges of the alarm's stored window
    if (c.cmd == wta_pkg::CMD_CHECK && c.id < ALARMS && $urandom_range(99) < 45) begin
      k = int'(c.id);
      case ($urandom_range(4))
        0: c.now = al_deadline[k];
        1: c.now = al_deadline[k] - 16'd1;
        2: c.now = al_deadline[k] + 16'($urandom_range(3));
        3: c.now = al_start[k] - 16'd1;
        default: c.now = al_start[k];
      endcase
    end
    roll = $urandom_range(99);
    if (roll < 10) c.tout = 16'(em);
    else if (roll < 15) c.tout = 16'(em + 1);
    else if (roll < 20) c.tout = '0;
    else if (roll < 30) c.tout = 16'($urandom);
    else c.tout = 16'($urandom_range(em));
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_cmd(input alarm_cmd_t beat, input logic known, input alarm_flags_t want);
    alarm_flags_t pred;
    while (!quiet && $urandom_range(99) < 8) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_cmd      <= beat.cmd;
    in_alarm_id <= beat.id;
    in_now_tick <= beat.now;
    in_timeout  <= beat.tout;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = apply_alarm_cmd(beat);
    flags_due.push_back(known ? want : pred);
  endtask

  // Only while idle: drain, let the pipeline settle, then one config beat.
  task automatic write_modulus(input logic [wta_pkg::MOD_W-1:0] value);
    start <= 1'b0;
    while (flags_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tb_modulus = value;
  endtask

  always @(posedge clk) begin : check_results
    alarm_flags_t want;
    if (rst_n && out_valid) begin
      if (flags_due.size() == 0) begin
        report_mismatch("result beat with no command pending");
      end else begin
        want = flags_due.pop_front();
        if (out_expired !== want.expired)
          report_mismatch($sformatf("expired got %b want %b", out_expired, want.expired));
        if (out_active !== want.active)
          report_mismatch($sformatf("active got %b want %b", out_active, want.active));
        if (out_status !== want.status)
          report_mismatch($sformatf("status got %b want %b", out_status, want.status));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("wrapping_timer_alarm_table: mismatch");
        $finish;
      end
    end
  end

  initial begin
    logic [wta_pkg::MOD_W-1:0] mod_plan [PHASES];
    mod_plan = '{17'h10000, 17'd1, 17'd0, 17'h1FFFF, 17'd100, 17'hFFFF,
                 17'h10000, 17'd2, 17'd1000, 17'd7};
    mod_plan[7] = 17'($urandom_range(1000, 2));
    mod_plan[8] = 17'($urandom_range(65536, 1000));
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_rows[i])
      send_cmd(directed_rows[i].beat, directed_rows[i].known, directed_rows[i].flags);
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) write_modulus(mod_plan[p]);
      quiet = (p == 3);
      repeat (PHASE_CMDS) send_cmd(pick_cmd(), 1'b0, '0);
    end
    start <= 1'b0;
    while (flags_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (flags_due.size() != 0) report_mismatch("results still pending at end");
    if (mismatch_count == 0)
      $display("wrapping_timer_alarm_table: match");
    else
      $display("wrapping_timer_alarm_table: mismatch");
    $finish;
  end

endmodule

[sim.f]
sv/wta_pkg.sv
sv/wta_entry_mem.sv
sv/wta_exec.sv
sv/wrapping_timer_alarm_table.sv
bench/wrapping_timer_alarm_table_tb.sv
